>>> sv/nwts_pkg.sv
`default_nettype none
package nwts_pkg;

   localparam int NODES     = 4;
   localparam int NODE_W    = 2;
   localparam int COUNT_W   = 24;
   localparam int DIST_W    = 8;
   localparam int ROW_W     = 32;
   localparam int PROD_W    = COUNT_W + DIST_W;
   // four products of 32 bits never reach 2^34
   localparam int WEIGHT_W  = 34;
   localparam int SCALED_W  = WEIGHT_W + 4;
   localparam int SEEN_W    = 3;
   localparam int CSR_IDX_W = 2;

   localparam logic [ROW_W-1:0] DIST_ROW_0_RST = 32'h1414140A;
   localparam logic [ROW_W-1:0] DIST_ROW_1_RST = 32'h14140A14;
   localparam logic [ROW_W-1:0] DIST_ROW_2_RST = 32'h140A1414;
   localparam logic [ROW_W-1:0] DIST_ROW_3_RST = 32'h0A141414;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIST_ROW_0 = 2'd0,
      CSR_DIST_ROW_1 = 2'd1,
      CSR_DIST_ROW_2 = 2'd2,
      CSR_DIST_ROW_3 = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [NODE_W-1:0]  home_node;
      logic [COUNT_W-1:0] access_count;
      logic               last_count;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0] dest_node;
      logic              migrate;
      logic              truncated;
   } rsp_type;

   typedef struct packed {
      logic                rd_en;
      logic [NODE_W-1:0]   rd_addr;
      logic                wr_en;
      logic [NODE_W-1:0]   wr_addr;
      logic [WEIGHT_W-1:0] wr_data;
      logic                clr;
   } wram_ctl_type;

endpackage
`default_nettype wire

>>> sv/nwts_wram.sv
`default_nettype none
module nwts_wram (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire nwts_pkg::wram_ctl_type        ctl,
   output logic [nwts_pkg::WEIGHT_W-1:0]      rd_weight
);
   import nwts_pkg::*;

   logic [WEIGHT_W-1:0] mem [NODES];
   logic [NODES-1:0]    vld_ff;
   logic [WEIGHT_W-1:0] rd_data_ff;
   logic                rd_vld_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[ctl.rd_addr];
      end
   end

   // an entry that was not written since the last clear reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (ctl.rd_en) begin
            rd_vld_ff <= vld_ff[ctl.rd_addr];
         end
         if (ctl.clr) begin
            vld_ff <= '0;
         end else if (ctl.wr_en) begin
            vld_ff[ctl.wr_addr] <= 1'b1;
         end
      end
   end

   assign rd_weight = rd_vld_ff ? rd_data_ff : '0;

endmodule
`default_nettype wire

>>> sv/numa_weighted_target_select_top.sv
`default_nettype none
// an item without the last mark keeps busy high while it updates the weights (one weight update per cycle)
// a last item gives its result strobe after the update phase, the scan phase reading
// the weight ram and the decision state; the strobe is registered from the decision state
// one item at a time; busy is low again in the cycle that shows the result
// a count beyond the node limit skips the update cycles
// synchronous reset clears weights, counts, flags and restores the distance rows
module numa_weighted_target_select_top #(
   parameter int NODE_LIMIT = 4
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     start,
   output logic                                          busy,
   input  wire nwts_pkg::req_type                        req_item,
   output logic                                          rsp_valid,
   output nwts_pkg::rsp_type                             rsp_item,
   input  wire logic                                     csr_we,
   input  wire logic [nwts_pkg::CSR_IDX_W-1:0]           csr_index,
   input  wire logic [nwts_pkg::ROW_W-1:0]               csr_wdata
);
   import nwts_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACC,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type           state_ff;
   logic [ROW_W-1:0]    dist_ff [NODES];
   logic [2:0]          acc_idx_ff;
   logic [2:0]          scan_idx_ff;
   logic [NODE_W-1:0]   home_ff;
   logic [COUNT_W-1:0]  cnt_ff;
   logic                last_ff;
   logic [NODE_W-1:0]   slot_ff;
   logic [SEEN_W-1:0]   counts_seen_ff;
   logic                overflow_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic                wr_pend_ff;
   logic [NODE_W-1:0]   wr_addr_ff;
   logic [WEIGHT_W-1:0] whome_ff;
   logic [WEIGHT_W-1:0] wmin_ff;
   logic [NODE_W-1:0]   pick_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;

   wram_ctl_type        ram_ctl;
   logic [WEIGHT_W-1:0] rd_weight;
   logic [DIST_W-1:0]   dist_byte;
   logic [NODE_W-1:0]   scan_node;
   logic                cand_ok;
   logic [SCALED_W-1:0] w_x11;
   logic [SCALED_W-1:0] wmin_x10;
   logic [SCALED_W-1:0] wmin_x11;
   logic [SCALED_W-1:0] whome_x10p10;
   logic                beats;
   logic                take_pick;
   logic                accept;

   nwts_wram u_wram (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ram_ctl),
      .rd_weight (rd_weight)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff[0] <= DIST_ROW_0_RST;
         dist_ff[1] <= DIST_ROW_1_RST;
         dist_ff[2] <= DIST_ROW_2_RST;
         dist_ff[3] <= DIST_ROW_3_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DIST_ROW_0: dist_ff[0] <= csr_wdata;
            CSR_DIST_ROW_1: dist_ff[1] <= csr_wdata;
            CSR_DIST_ROW_2: dist_ff[2] <= csr_wdata;
            CSR_DIST_ROW_3: dist_ff[3] <= csr_wdata;
            default:        dist_ff[0] <= dist_ff[0];
         endcase
      end
   end

   assign accept    = start && (state_ff == ST_IDLE);
   assign dist_byte = dist_ff[acc_idx_ff[NODE_W-1:0]][slot_ff*DIST_W +: DIST_W];
   // node whose weight arrives from the ram this scan cycle
   assign scan_node = NODE_W'(scan_idx_ff - 3'd2);
   assign cand_ok   = ({1'b0, scan_node} < counts_seen_ff) && (scan_node != home_ff);

   // w + w/10 < min is the same as 11*w < 10*min for integers
   assign w_x11    = (SCALED_W'(rd_weight) << 3) + (SCALED_W'(rd_weight) << 1)
                     + SCALED_W'(rd_weight);
   assign wmin_x10 = (SCALED_W'(wmin_ff) << 3) + (SCALED_W'(wmin_ff) << 1);
   assign wmin_x11 = wmin_x10 + SCALED_W'(wmin_ff);
   assign whome_x10p10 = (SCALED_W'(whome_ff) << 3) + (SCALED_W'(whome_ff) << 1)
                         + SCALED_W'(10);
   assign beats     = w_x11 < wmin_x10;
   assign take_pick = wmin_x11 < whome_x10p10;

   always_comb begin
      ram_ctl         = '0;
      ram_ctl.wr_en   = wr_pend_ff;
      ram_ctl.wr_addr = wr_addr_ff;
      ram_ctl.wr_data = rd_weight + WEIGHT_W'(prod_ff);
      ram_ctl.clr     = (state_ff == ST_DONE);
      case (state_ff)
         ST_ACC: begin
            ram_ctl.rd_en   = ~acc_idx_ff[2];
            ram_ctl.rd_addr = acc_idx_ff[NODE_W-1:0];
         end
         ST_SCAN: begin
            ram_ctl.rd_en   = (scan_idx_ff <= 3'd4);
            ram_ctl.rd_addr = (scan_idx_ff == 3'd0) ? home_ff
                              : NODE_W'(scan_idx_ff - 3'd1);
         end
         default: begin
            ram_ctl.rd_en   = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         acc_idx_ff     <= '0;
         scan_idx_ff    <= '0;
         counts_seen_ff <= '0;
         overflow_ff    <= 1'b0;
         wr_pend_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  home_ff     <= req_item.home_node;
                  cnt_ff      <= req_item.access_count;
                  last_ff     <= req_item.last_count;
                  acc_idx_ff  <= '0;
                  scan_idx_ff <= '0;
                  if (counts_seen_ff < SEEN_W'(NODE_LIMIT)) begin
                     slot_ff        <= counts_seen_ff[NODE_W-1:0];
                     counts_seen_ff <= counts_seen_ff + 3'd1;
                     state_ff       <= ST_ACC;
                  end else begin
                     overflow_ff <= 1'b1;
                     state_ff    <= req_item.last_count ? ST_SCAN : ST_IDLE;
                  end
               end
            end
            ST_ACC: begin
               // read node k while writing back node k-1
               if (!acc_idx_ff[2]) begin
                  prod_ff    <= PROD_W'(dist_byte) * PROD_W'(cnt_ff);
                  wr_pend_ff <= 1'b1;
                  wr_addr_ff <= acc_idx_ff[NODE_W-1:0];
                  acc_idx_ff <= acc_idx_ff + 3'd1;
               end else begin
                  wr_pend_ff <= 1'b0;
                  state_ff   <= last_ff ? ST_SCAN : ST_IDLE;
               end
            end
            ST_SCAN: begin
               if (scan_idx_ff == 3'd1) begin
                  whome_ff <= rd_weight;
                  wmin_ff  <= rd_weight;
                  pick_ff  <= '0;
               end else if (scan_idx_ff >= 3'd2 && cand_ok && beats) begin
                  wmin_ff <= rd_weight;
                  pick_ff <= scan_node;
               end
               scan_idx_ff <= scan_idx_ff + 3'd1;
               if (scan_idx_ff == 3'd5) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               rsp_valid_ff          <= 1'b1;
               rsp_ff.dest_node      <= take_pick ? pick_ff : home_ff;
               rsp_ff.migrate        <= take_pick && (pick_ff != home_ff);
               rsp_ff.truncated      <= overflow_ff;
               counts_seen_ff        <= '0;
               overflow_ff           <= 1'b0;
               state_ff              <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_seen_limit: assert property (@(posedge clock) disable iff (reset)
      counts_seen_ff <= SEEN_W'(NODE_LIMIT))
      else $error("count of accepted counts beyond node limit");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_migrate_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.migrate == (rsp_item.dest_node != home_ff)))
      else $error("migrate flag disagrees with destination and home node");

   a_write_in_acc: assert property (@(posedge clock) disable iff (reset)
      wr_pend_ff |-> (state_ff == ST_ACC))
      else $error("weight write-back outside update phase");

   a_full_drops: assert property (@(posedge clock) disable iff (reset)
      (accept && counts_seen_ff == SEEN_W'(NODE_LIMIT)) |=> overflow_ff)
      else $error("dropped count not flagged");

endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import nwts_pkg::*;

   localparam int NODE_LIMIT = 4;
   localparam int SETTLE_CYC = 20;

   logic          clock;
   logic          reset = 1'b1;
   logic          start = 1'b0;
   logic          busy;
   req_type       req_item = '0;
   logic          rsp_valid;
   rsp_type       rsp_item;
   logic          csr_we = 1'b0;
   csr_index_type csr_index = CSR_DIST_ROW_0;
   logic [31:0]   csr_wdata = '0;

   // predictor state
   logic [31:0]   dist_rows [4];
   logic [39:0]   weight_acc [4];
   int            counts_taken;
   bit            dropped_count;

   req_type       count_q [$];
   rsp_type       selection_q [$];
   int            gap_left = 0;
   bit            gaps_on = 1'b1;
   int            fail_count = 0;

   numa_weighted_target_select_top #(.NODE_LIMIT(NODE_LIMIT)) DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #(64'd5_000_000);
      $display("tb: failure");
      $finish;
   end

   function automatic void clear_page();
      for (int n = 0; n < 4; n++) weight_acc[n] = '0;
      counts_taken  = 0;
      dropped_count = 1'b0;
   endfunction

   task automatic predict_selection(input req_type it);
      logic [39:0] wmin;
      logic [39:0] whome;
      logic [39:0] w;
      logic [1:0]  pick;
      logic [1:0]  dest;
      rsp_type     r;
      if (counts_taken < NODE_LIMIT) begin
         for (int n = 0; n < 4; n++)
            weight_acc[n] = weight_acc[n]
                          + 40'(dist_rows[n][8*counts_taken +: 8]) * 40'(it.access_count);
         counts_taken++;
      end else begin
         dropped_count = 1'b1;
      end
      if (it.last_count) begin
         whome = weight_acc[it.home_node];
         wmin  = whome;
         pick  = 2'd0;
         for (int i = 0; i < counts_taken && i < 4; i++) begin
            if (i != it.home_node) begin
               w = weight_acc[i];
               if (w + w / 10 < wmin) begin
                  wmin = w;
                  pick = 2'(i);
               end
            end
         end
         dest = (wmin + wmin / 10 <= whome) ? pick : it.home_node;
         r.dest_node   = dest;
         r.migrate     = (dest != it.home_node);
         r.truncated   = dropped_count;
         selection_q.push_back(r);
         clear_page();
      end
   endtask

   // driver: hold start until the transfer, then take the next count or a gap
   always @(posedge clock) begin
      if (reset) begin
         start    <= 1'b0;
         gap_left = 0;
      end else begin
         if (start && !busy) begin
            predict_selection(req_item);
            if (gaps_on && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 14);
         end
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (count_q.size() != 0) begin
               req_item <= count_q.pop_front();
               start    <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : check_selection
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (selection_q.size() == 0) begin
            $display("%0t: unexpected result expected none actual %p", $time, rsp_item);
            fail_count++;
         end else begin
            want = selection_q.pop_front();
            if (rsp_item.dest_node !== want.dest_node) begin
               $display("%0t: dest_node expected %0d actual %0d", $time,
                        want.dest_node, rsp_item.dest_node);
               fail_count++;
            end
            if (rsp_item.migrate !== want.migrate) begin
               $display("%0t: migrate expected %0b actual %0b", $time,
                        want.migrate, rsp_item.migrate);
               fail_count++;
            end
            if (rsp_item.truncated !== want.truncated) begin
               $display("%0t: truncated expected %0b actual %0b", $time,
                        want.truncated, rsp_item.truncated);
               fail_count++;
            end
         end
      end
   end

   task automatic add_count(input logic [1:0] home, input logic [23:0] cnt, input bit last);
      req_type it;
      it.home_node    = home;
      it.access_count = cnt;
      it.last_count   = last;
      count_q.push_back(it);
   endtask

   function automatic logic [23:0] random_count(input bit hot);
      logic [23:0] c;
      case ($urandom_range(0, 4))
         0:       c = 24'($urandom());
         1:       c = 24'($urandom_range(0, 15));
         2:       c = 24'hFFFFFF;
         3:       c = 24'h0;
         default: c = 24'($urandom_range(900, 1100));
      endcase
      if (hot && $urandom_range(0, 1) == 1) c = 24'($urandom()) | 24'h800000;
      return c;
   endfunction

   function automatic logic [31:0] random_row();
      logic [31:0] r;
      for (int b = 0; b < 4; b++) begin
         case ($urandom_range(0, 3))
            0:       r[8*b +: 8] = 8'h00;
            1:       r[8*b +: 8] = 8'hFF;
            default: r[8*b +: 8] = 8'($urandom_range(0, 255));
         endcase
      end
      return r;
   endfunction

   task automatic queue_page(input int len);
      int hot;
      hot = $urandom_range(0, len - 1);
      for (int i = 0; i < len; i++)
         add_count(2'($urandom_range(0, 3)), random_count(i == hot), i == len - 1);
   endtask

   task automatic write_row(input csr_index_type idx, input logic [31:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      dist_rows[idx] = val;
   endtask

   // wait for the block to go quiet with nothing outstanding
   task automatic drain();
      @(negedge clock);
      while (count_q.size() != 0 || start || gap_left != 0 || selection_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   initial begin
      int phase_items;
      int len;
      dist_rows[0] = DIST_ROW_0_RST;
      dist_rows[1] = DIST_ROW_1_RST;
      dist_rows[2] = DIST_ROW_2_RST;
      dist_rows[3] = DIST_ROW_3_RST;
      clear_page();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // all counts at full scale
      for (int i = 0; i < 4; i++) add_count(2'd3, 24'hFFFFFF, i == 3);
      // light page: no better node and home weight below 10
      add_count(2'd2, 24'h0, 1'b1);
      // single count, only node 0 is a candidate
      add_count(2'd1, 24'hFFFFFF, 1'b1);
      // extra counts dropped before the last mark
      add_count(2'd0, 24'd100, 1'b0);
      for (int i = 0; i < 4; i++) add_count(2'd0, (i < 3) ? 24'd0 : 24'd5, 1'b0);
      add_count(2'd0, 24'd5, 1'b1);
      // hot remote node pulls the page over
      for (int i = 0; i < 4; i++) add_count(2'd0, (i == 2) ? 24'd1000 : 24'd0, i == 3);
      // hot home node keeps the page
      for (int i = 0; i < 4; i++) add_count(2'd3, (i == 3) ? 24'd5000 : 24'd1, i == 3);
      // the last mark itself arrives past the node limit
      for (int i = 0; i < 5; i++) add_count(2'd1, 24'($urandom()), i == 4);
      drain();

      for (int ph = 1; ph <= 7; ph++) begin
         if (ph == 7) gaps_on = 1'b0;
         for (int r = 0; r < 4; r++) begin
            case (ph)
               1:       write_row(csr_index_type'(r), 32'hFFFFFFFF);
               2:       write_row(csr_index_type'(r), 32'h0);
               3:       write_row(csr_index_type'(r), (r == 0) ? DIST_ROW_0_RST :
                                                      (r == 1) ? DIST_ROW_1_RST :
                                                      (r == 2) ? DIST_ROW_2_RST :
                                                                 DIST_ROW_3_RST);
               4, 6:    write_row(csr_index_type'(r), $urandom());
               default: write_row(csr_index_type'(r), random_row());
            endcase
         end
         phase_items = 0;
         while (phase_items < 285) begin
            len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(5, 7);
            queue_page(len);
            phase_items += len;
         end
         drain();
      end

      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
